// ===== sv/atuv_pkg.sv =====
`timescale 1ns / 1ps
// atuv_pkg: shared constants, item types and lane control types of the
// atlas tile UV generator. No dependencies.
package atuv_pkg;

  localparam int UV_FRAC_BITS   = 16;
  localparam int ATLAS_DIM_BITS = 12;
  localparam int MAX_SUBDIV     = 8;

  localparam int ATLAS_W   = ATLAS_DIM_BITS + 1;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int REG_W     = 12;
  localparam int EXT_W     = 13;
  localparam int SUB_W     = 4;
  localparam int PAD_W     = 8;
  localparam int IDX_W     = $clog2(MAX_SUBDIV);
  localparam int PX_W      = REG_W + EXT_W;
  localparam int BLK_W     = EXT_W + 1;

  localparam logic [CFG_W-1:0]   ATLAS_RST = CFG_W'(1024);
  localparam logic [ATLAS_W-1:0] ATLAS_LIM = ATLAS_W'(1) << ATLAS_DIM_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [REG_W-1:0] region_x;
    logic [REG_W-1:0] region_y;
    logic [EXT_W-1:0] extent_w;
    logic [EXT_W-1:0] extent_h;
    logic [SUB_W-1:0] cols;
    logic [SUB_W-1:0] rows;
    logic [PAD_W-1:0] pad_x;
    logic [PAD_W-1:0] pad_y;
    logic             reversed;
  } in_item_t;

  typedef struct packed {
    logic [UV_FRAC_BITS-1:0] u_origin;
    logic [UV_FRAC_BITS-1:0] v_origin;
    logic [UV_FRAC_BITS-1:0] u_size;
    logic [UV_FRAC_BITS-1:0] v_size;
    logic                    status;
    logic                    last;
  } out_item_t;

  typedef enum logic [3:0] {
    LOP_HOLD,
    LOP_LOAD,
    LOP_MAC_PREP,
    LOP_NUM,
    LOP_NDIV,
    LOP_BLOCK,
    LOP_UV_SIZE,
    LOP_UV_ORG,
    LOP_UV_STEP,
    LOP_SAVE,
    LOP_IDX,
    LOP_MAC_IDX
  } lane_op_e;

  typedef struct packed {
    lane_op_e         op;
    logic             div_mode;
    logic [IDX_W-1:0] idx;
  } lane_ctl_t;

  typedef struct packed {
    logic                    err;
    logic [UV_FRAC_BITS-1:0] size_uv;
    logic [UV_FRAC_BITS-1:0] uv;
  } lane_res_t;

endpackage

// ===== sv/atuv_lane.sv =====
`timescale 1ns / 1ps
// atuv_lane: one axis of the tile UV generator; bit-serial multiply,
// divide by subdivision count and pixel-to-UV divide. Uses atuv_pkg.
module atuv_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  atuv_pkg::lane_ctl_t              ctl_i,
  input  logic [atuv_pkg::REG_W-1:0]       region_i,
  input  logic [atuv_pkg::EXT_W-1:0]       extent_i,
  input  logic [atuv_pkg::SUB_W-1:0]       nsub_i,
  input  logic [atuv_pkg::PAD_W-1:0]       pad_i,
  input  logic [atuv_pkg::ATLAS_W-1:0]     atlas_i,
  output atuv_pkg::lane_res_t              res_o
);

  localparam int PX_W  = atuv_pkg::PX_W;
  localparam int REG_W = atuv_pkg::REG_W;
  localparam int EXT_W = atuv_pkg::EXT_W;
  localparam int SUB_W = atuv_pkg::SUB_W;
  localparam int IDX_W = atuv_pkg::IDX_W;
  localparam int AT_W  = atuv_pkg::ATLAS_W;
  localparam int BLK_W = atuv_pkg::BLK_W;
  localparam int UV_W  = atuv_pkg::UV_FRAC_BITS;

  logic                            err_q;
  logic                            div_q;
  logic [REG_W-1:0]                region_q;
  logic [EXT_W-1:0]                ext_q;
  logic [SUB_W-1:0]                n_q;
  logic [atuv_pkg::PAD_W-1:0]      pad_q;
  logic [AT_W-1:0]                 atl_q;
  logic [PX_W-1:0]                 acc_q;
  logic [REG_W-1:0]                mplier_q;
  logic [EXT_W-1:0]                dvd_q;
  logic [SUB_W-1:0]                nrem_q;
  logic [EXT_W-1:0]                tile_q;
  logic [BLK_W-1:0]                block_q;
  logic                            sat_q;
  logic [AT_W-1:0]                 rem_q;
  logic [UV_W-1:0]                 q_q;
  logic [UV_W-1:0]                 size_q;

  logic [SUB_W-1:0]  nm1;
  logic [PX_W-1:0]   mcand;
  logic [PX_W-1:0]   acc_mac;
  logic [SUB_W:0]    ndiv_t;
  logic              ndiv_ge;
  logic [BLK_W-1:0]  blk;
  logic [PX_W-1:0]   px_size;
  logic [PX_W-1:0]   px_org;
  logic [PX_W-1:0]   px_sel;
  logic [AT_W:0]     uv_t;
  logic              uv_ge;
  logic [UV_W-1:0]   uv_res;
  logic              load_err;

  always_comb begin
    nm1 = nsub_i - SUB_W'(1);
    if (ctl_i.op == atuv_pkg::LOP_MAC_IDX) begin
      mcand = PX_W'(block_q);
    end else begin
      mcand = div_q ? PX_W'(pad_q) : PX_W'(ext_q);
    end
    acc_mac = {acc_q[PX_W-2:0], 1'b0} + (mplier_q[REG_W-1] ? mcand : '0);
    // restoring divide by the subdivision count, one quotient bit a cycle
    ndiv_t  = {nrem_q, dvd_q[EXT_W-1]};
    ndiv_ge = ndiv_t >= {1'b0, n_q};
    blk     = BLK_W'(dvd_q) + BLK_W'(pad_q);
    px_size = div_q ? PX_W'(tile_q) : PX_W'(ext_q);
    px_org  = div_q ? (acc_q + PX_W'(region_q)) : acc_q;
    px_sel  = (ctl_i.op == atuv_pkg::LOP_UV_ORG) ? px_org : px_size;
    // px * 2^UV_W / atlas, remainder kept below atlas
    uv_t    = {rem_q, 1'b0};
    uv_ge   = uv_t >= {1'b0, atl_q};
    uv_res  = sat_q ? '1 : q_q;
    if (ctl_i.div_mode) begin
      load_err = (nsub_i == '0) || (nsub_i > SUB_W'(atuv_pkg::MAX_SUBDIV));
    end else begin
      load_err = (extent_i == '0) || (PX_W'(extent_i) > PX_W'(atlas_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      unique case (ctl_i.op)
        atuv_pkg::LOP_LOAD:  err_q <= load_err;
        atuv_pkg::LOP_NUM:   err_q <= err_q | (PX_W'(ext_q) < acc_q);
        atuv_pkg::LOP_BLOCK: err_q <= err_q | (dvd_q == '0) | (blk > BLK_W'(atl_q));
        default:             err_q <= err_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      atuv_pkg::LOP_HOLD: begin
      end
      atuv_pkg::LOP_LOAD: begin
        div_q    <= ctl_i.div_mode;
        region_q <= region_i;
        ext_q    <= extent_i;
        n_q      <= nsub_i;
        pad_q    <= pad_i;
        atl_q    <= atlas_i;
        acc_q    <= '0;
        mplier_q <= ctl_i.div_mode ? {nm1[IDX_W-1:0], {(REG_W-IDX_W){1'b0}}} : region_i;
      end
      atuv_pkg::LOP_MAC_PREP, atuv_pkg::LOP_MAC_IDX: begin
        acc_q    <= acc_mac;
        mplier_q <= {mplier_q[REG_W-2:0], 1'b0};
      end
      atuv_pkg::LOP_NUM: begin
        dvd_q  <= ext_q - acc_q[EXT_W-1:0];
        nrem_q <= '0;
      end
      atuv_pkg::LOP_NDIV: begin
        nrem_q <= ndiv_ge ? SUB_W'(ndiv_t - {1'b0, n_q}) : ndiv_t[SUB_W-1:0];
        dvd_q  <= {dvd_q[EXT_W-2:0], ndiv_ge};
      end
      atuv_pkg::LOP_BLOCK: begin
        tile_q  <= dvd_q;
        block_q <= blk;
      end
      atuv_pkg::LOP_UV_SIZE, atuv_pkg::LOP_UV_ORG: begin
        sat_q <= px_sel >= PX_W'(atl_q);
        rem_q <= px_sel[AT_W-1:0];
        q_q   <= '0;
      end
      atuv_pkg::LOP_UV_STEP: begin
        rem_q <= uv_ge ? AT_W'(uv_t - {1'b0, atl_q}) : uv_t[AT_W-1:0];
        q_q   <= {q_q[UV_W-2:0], uv_ge};
      end
      atuv_pkg::LOP_SAVE: begin
        size_q <= uv_res;
      end
      atuv_pkg::LOP_IDX: begin
        acc_q    <= '0;
        mplier_q <= {ctl_i.idx, {(REG_W-IDX_W){1'b0}}};
      end
      default: begin
      end
    endcase
  end

  assign res_o.err     = err_q;
  assign res_o.size_uv = size_q;
  assign res_o.uv      = uv_res;

endmodule

// ===== sv/atlas_tile_uv_generator_unit.sv =====
`timescale 1ns / 1ps
// atlas_tile_uv_generator_unit: top level; sequencer, config registers,
// output register and two axis lanes. Uses atuv_pkg and atuv_lane.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i    | region descriptor in
//  out     | out_valid_o, out_stall_i, out_data_o | one tile UV rect out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | atlas size write
//
// One region item at a time. Rect mode: a 12-step multiply and two 16-step UV
// divides per item. Divided mode: each tile costs a 3-step index multiply and
// one 16-step UV divide; the size divide runs once. Bad geometry is answered
// before any UV divide starts.
// The UV divider is bit-serial, one quotient bit a cycle.
// Reset is asynchronous, active low; atlas size resets to 1024 x 1024.
// A stalled output only holds back the next tile; a new item is taken as soon
// as the last tile of the current one sits in the output register.
module atlas_tile_uv_generator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  atuv_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output atuv_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [atuv_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [atuv_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int IDX_W = atuv_pkg::IDX_W;
  localparam int SUB_W = atuv_pkg::SUB_W;
  localparam int CFG_W = atuv_pkg::CFG_W;
  localparam int AT_W  = atuv_pkg::ATLAS_W;
  localparam int CNT_W = $clog2(atuv_pkg::UV_FRAC_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PMUL,    // region*extent (rect) or pad*(n-1) (divided)
    S_NUM,
    S_NDIV,    // tile = (extent - pad*(n-1)) / n
    S_BLOCK,
    S_CHECK,
    S_SDIV,    // size UV
    S_SSAVE,
    S_TILE,
    S_OMUL,    // idx*block
    S_OSTART,
    S_ODIV,    // origin UV
    S_EMIT,
    S_ERR
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     col_q;
  logic [IDX_W-1:0]     row_q;
  logic [IDX_W-1:0]     cols_m1_q;
  logic [IDX_W-1:0]     rows_m1_q;
  logic                 func_q;
  logic                 rev_q;
  logic                 out_valid_q;
  atuv_pkg::out_item_t  out_data_q;

  logic [CFG_W-1:0]     atlas_w_q;
  logic [CFG_W-1:0]     atlas_h_q;

  logic                 in_acc;
  logic                 slot_free;
  logic                 tile_final;
  logic                 lane_err;
  logic [SUB_W-1:0]     cols_m1;
  logic [SUB_W-1:0]     rows_m1;
  logic [AT_W-1:0]      atlas_x;
  logic [AT_W-1:0]      atlas_y;
  logic [IDX_W-1:0]     ci;
  logic [IDX_W-1:0]     ri;
  atuv_pkg::lane_op_e   lop;
  atuv_pkg::lane_ctl_t  ctl_x;
  atuv_pkg::lane_ctl_t  ctl_y;
  atuv_pkg::lane_res_t  res_x;
  atuv_pkg::lane_res_t  res_y;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= atuv_pkg::ATLAS_RST;
      atlas_h_q <= atuv_pkg::ATLAS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atuv_pkg::CFG_ATLAS_WIDTH:  atlas_w_q <= cfg_wdata_i;
        atuv_pkg::CFG_ATLAS_HEIGHT: atlas_h_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // atlas sizes above 2^ATLAS_DIM_BITS clamp to it
  assign atlas_x = (atlas_w_q > CFG_W'(atuv_pkg::ATLAS_LIM)) ? atuv_pkg::ATLAS_LIM
                                                              : AT_W'(atlas_w_q);
  assign atlas_y = (atlas_h_q > CFG_W'(atuv_pkg::ATLAS_LIM)) ? atuv_pkg::ATLAS_LIM
                                                              : AT_W'(atlas_h_q);

  // ---------------------------------------------------------------- control
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign tile_final = (col_q == cols_m1_q) && (row_q == rows_m1_q);
  assign lane_err   = res_x.err | res_y.err;
  assign cols_m1    = in_data_i.cols - SUB_W'(1);
  assign rows_m1    = in_data_i.rows - SUB_W'(1);
  // reversed order walks the grid from the far corner
  assign ci         = rev_q ? (cols_m1_q - col_q) : col_q;
  assign ri         = rev_q ? (rows_m1_q - row_q) : row_q;

  always_comb begin
    unique case (state_q)
      S_IDLE:          lop = in_acc ? atuv_pkg::LOP_LOAD : atuv_pkg::LOP_HOLD;
      S_PMUL:          lop = atuv_pkg::LOP_MAC_PREP;
      S_NUM:           lop = atuv_pkg::LOP_NUM;
      S_NDIV:          lop = atuv_pkg::LOP_NDIV;
      S_BLOCK:         lop = atuv_pkg::LOP_BLOCK;
      S_CHECK:         lop = lane_err ? atuv_pkg::LOP_HOLD : atuv_pkg::LOP_UV_SIZE;
      S_SDIV, S_ODIV:  lop = atuv_pkg::LOP_UV_STEP;
      S_SSAVE:         lop = atuv_pkg::LOP_SAVE;
      S_TILE:          lop = atuv_pkg::LOP_IDX;
      S_OMUL:          lop = atuv_pkg::LOP_MAC_IDX;
      S_OSTART:        lop = atuv_pkg::LOP_UV_ORG;
      default:         lop = atuv_pkg::LOP_HOLD;
    endcase
    ctl_x.op       = lop;
    ctl_x.div_mode = in_data_i.func;
    ctl_x.idx      = ci;
    ctl_y.op       = lop;
    ctl_y.div_mode = in_data_i.func;
    ctl_y.idx      = ri;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cols_m1_q   <= '0;
      rows_m1_q   <= '0;
      func_q      <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            func_q    <= in_data_i.func;
            rev_q     <= in_data_i.reversed;
            cols_m1_q <= cols_m1[IDX_W-1:0];
            rows_m1_q <= rows_m1[IDX_W-1:0];
            col_q     <= '0;
            row_q     <= '0;
            cnt_q     <= in_data_i.func ? CNT_W'(IDX_W) : CNT_W'(atuv_pkg::REG_W);
            state_q   <= S_PMUL;
          end
        end
        S_PMUL: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= func_q ? S_NUM : S_CHECK;
          end
        end
        S_NUM: begin
          cnt_q   <= CNT_W'(atuv_pkg::EXT_W);
          state_q <= S_NDIV;
        end
        S_NDIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_BLOCK;
          end
        end
        S_BLOCK: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (lane_err) begin
            state_q <= S_ERR;
          end else begin
            cnt_q   <= CNT_W'(atuv_pkg::UV_FRAC_BITS);
            state_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_SSAVE;
          end
        end
        S_SSAVE: begin
          state_q <= func_q ? S_TILE : S_OSTART;
        end
        S_TILE: begin
          cnt_q   <= CNT_W'(IDX_W);
          state_q <= S_OMUL;
        end
        S_OMUL: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_OSTART;
          end
        end
        S_OSTART: begin
          cnt_q   <= CNT_W'(atuv_pkg::UV_FRAC_BITS);
          state_q <= S_ODIV;
        end
        S_ODIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q         <= 1'b1;
            out_data_q.u_origin <= res_x.uv;
            out_data_q.v_origin <= res_y.uv;
            out_data_q.u_size   <= res_x.size_uv;
            out_data_q.v_size   <= res_y.size_uv;
            out_data_q.status   <= 1'b0;
            out_data_q.last     <= !func_q || tile_final;
            if (!func_q || tile_final) begin
              state_q <= S_IDLE;
            end else begin
              // column outer, row inner
              if (row_q == rows_m1_q) begin
                row_q <= '0;
                col_q <= col_q + IDX_W'(1);
              end else begin
                row_q <= row_q + IDX_W'(1);
              end
              state_q <= S_TILE;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_valid_q       <= 1'b1;
            out_data_q        <= '0;
            out_data_q.status <= 1'b1;
            out_data_q.last   <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- lanes
  atuv_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_x),
    .region_i (in_data_i.region_x),
    .extent_i (in_data_i.extent_w),
    .nsub_i   (in_data_i.cols),
    .pad_i    (in_data_i.pad_x),
    .atlas_i  (atlas_x),
    .res_o    (res_x)
  );

  atuv_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_y),
    .region_i (in_data_i.region_y),
    .extent_i (in_data_i.extent_h),
    .nsub_i   (in_data_i.rows),
    .pad_i    (in_data_i.pad_y),
    .atlas_i  (atlas_y),
    .res_o    (res_y)
  );

`ifndef ASSERT_OFF
  ap_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous region still in work");

  ap_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> out_data_o.last)
    else $error("bad geometry result not flagged last");

  ap_err_zero_uv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (out_data_o.u_origin == '0 && out_data_o.v_origin == '0 &&
       out_data_o.u_size == '0 && out_data_o.v_size == '0))
    else $error("bad geometry result carries nonzero UV");

  ap_tile_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TILE || state_q == S_OMUL) |->
      (col_q <= cols_m1_q && row_q <= rows_m1_q))
    else $error("tile counters outside the grid");

  ap_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && out_stall_i) |=> (state_q == S_EMIT))
    else $error("tile left emit while output register was still full");
`endif

endmodule
